>>> rtl/gpg_pkg.sv
// Shared types, constants and helpers of the glyph pixel generator
`default_nettype none

package gpg_pkg;

    // Glyph store geometry (depth is a power of two: addresses wrap by truncation)
    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int MAX_SCALE   = 8;
    localparam int REP_W       = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    // Leftmost pixel of a row-order font byte
    localparam logic [7:0] ROW_LEFT_BIT = 8'h80;

    // Command codes of the input word
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    // Configuration register indices
    typedef enum logic [2:0] {
        REG_FIRST_CODE   = 3'd0,
        REG_LAST_CODE    = 3'd1,
        REG_GLYPH_WIDTH  = 3'd2,
        REG_GLYPH_HEIGHT = 3'd3,
        REG_GLYPH_INVERT = 3'd4,
        REG_COLUMN_ORDER = 3'd5,
        REG_TRANSPARENT  = 3'd6,
        REG_SWAP         = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] first_code;
        logic [7:0] last_code;
        logic [3:0] glyph_width;
        logic [4:0] glyph_height;
        logic       glyph_invert;
        logic       column_order;
        logic       transparent;
        logic       swap_ink_paper;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        first_code:     8'd32,
        last_code:      8'd127,
        glyph_width:    4'd5,
        glyph_height:   5'd5,
        glyph_invert:   1'b0,
        column_order:   1'b0,
        transparent:    1'b0,
        swap_ink_paper: 1'b0
    };

    // Pixel context handed from the sequencer to the shading stage
    typedef struct packed {
        logic [8:0]  px;
        logic [8:0]  py;
        logic [15:0] fore;
        logic [15:0] back;
        logic [2:0]  bit_sel;
        logic        row_tall;
        logic        last;
    } t_pix;

    function automatic logic [3:0] f_width(input logic [3:0] w);
        if (w == 4'd0) return 4'd1;
        if (w > 4'd8) return 4'd8;
        return w;
    endfunction

    function automatic logic [4:0] f_height(input logic [4:0] h);
        if (h == 5'd0) return 5'd1;
        if (h > 5'd16) return 5'd16;
        return h;
    endfunction

    function automatic logic [3:0] f_scale(input logic [3:0] s);
        if (s == 4'd0) return 4'd1;
        if ({1'b0, s} > 5'(MAX_SCALE)) return 4'(MAX_SCALE);
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gpg_if.sv
// Valid/ready channel interfaces for command words and pixel words
`default_nettype none

interface gpg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [11:0] font_address;
    logic [7:0]  font_byte;
    logic [7:0]  char_code;
    logic [8:0]  origin_x;
    logic [8:0]  origin_y;
    logic [3:0]  scale;
    logic [15:0] ink;
    logic [15:0] paper;

    modport source (
        output valid, command, font_address, font_byte, char_code,
               origin_x, origin_y, scale, ink, paper,
        input  ready
    );
    modport sink (
        input  valid, command, font_address, font_byte, char_code,
               origin_x, origin_y, scale, ink, paper,
        output ready
    );
endinterface

interface gpg_out_if;
    logic        valid;
    logic        ready;
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [15:0] colour;
    logic        write_enable;
    logic        last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, colour, write_enable, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, colour, write_enable, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/glyph_pixel_generator.sv
// Glyph pixel generator top level: configuration registers, glyph store and pipeline
// A tick's store read and context are registered, then shaded into the registered output word.
// Throughput: one word per cycle unless output stalls; a font write is seen by a tick
// accepted the next cycle. The single store read port, one read per tick, sets the rate.
// Reset: registers return to defaults, drawing stops and the pipeline empties.
// The glyph store is not cleared by reset; there is no clearing pass.
`default_nettype none

module glyph_pixel_generator (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    gpg_in_if.sink          i_cmd,
    gpg_out_if.source       o_pix
);
    import gpg_pkg::*;

    t_cfg              r_cfg;
    logic              w_fire;
    logic              w_stage_free;
    logic              w_ram_we, w_ram_re;
    logic [ADDR_W-1:0] w_ram_waddr, w_ram_raddr;
    logic [7:0]        w_ram_wdata, w_ram_rdata;
    logic              w_tick_valid;
    t_pix              w_pix;

    assign i_cmd.ready = i_rst_n & w_stage_free;
    assign w_fire      = i_cmd.valid & i_cmd.ready;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FIRST_CODE:   r_cfg.first_code     <= i_cfg_data;
                REG_LAST_CODE:    r_cfg.last_code      <= i_cfg_data;
                REG_GLYPH_WIDTH:  r_cfg.glyph_width    <= i_cfg_data[3:0];
                REG_GLYPH_HEIGHT: r_cfg.glyph_height   <= i_cfg_data[4:0];
                REG_GLYPH_INVERT: r_cfg.glyph_invert   <= i_cfg_data[0];
                REG_COLUMN_ORDER: r_cfg.column_order   <= i_cfg_data[0];
                REG_TRANSPARENT:  r_cfg.transparent    <= i_cfg_data[0];
                REG_SWAP:         r_cfg.swap_ink_paper <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    gpg_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_fire         (w_fire),
        .i_command      (i_cmd.command),
        .i_font_address (i_cmd.font_address),
        .i_font_byte    (i_cmd.font_byte),
        .i_char_code    (i_cmd.char_code),
        .i_origin_x     (i_cmd.origin_x),
        .i_origin_y     (i_cmd.origin_y),
        .i_scale        (i_cmd.scale),
        .i_ink          (i_cmd.ink),
        .i_paper        (i_cmd.paper),
        .o_ram_we       (w_ram_we),
        .o_ram_waddr    (w_ram_waddr),
        .o_ram_wdata    (w_ram_wdata),
        .o_ram_re       (w_ram_re),
        .o_ram_raddr    (w_ram_raddr),
        .o_tick_valid   (w_tick_valid),
        .o_pix          (w_pix)
    );

    gpg_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_glyph_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    gpg_shade u_shade (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_tick_valid   (w_tick_valid),
        .i_pix          (w_pix),
        .i_rdata        (w_ram_rdata),
        .i_out_ready    (o_pix.ready),
        .o_stage_free   (w_stage_free),
        .o_out_valid    (o_pix.valid),
        .o_pixel_x      (o_pix.pixel_x),
        .o_pixel_y      (o_pix.pixel_y),
        .o_colour       (o_pix.colour),
        .o_write_enable (o_pix.write_enable),
        .o_last_pixel   (o_pix.last_pixel)
    );

endmodule

`default_nettype wire

>>> rtl/gpg_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module gpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/gpg_seq.sv
// Cell sequencer: latches a character, walks the scaled cell, issues store accesses
`default_nettype none

module gpg_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire gpg_pkg::t_cfg        i_cfg,
    input  wire logic                 i_fire,
    input  wire logic [1:0]           i_command,
    input  wire logic [11:0]          i_font_address,
    input  wire logic [7:0]           i_font_byte,
    input  wire logic [7:0]           i_char_code,
    input  wire logic [8:0]           i_origin_x,
    input  wire logic [8:0]           i_origin_y,
    input  wire logic [3:0]           i_scale,
    input  wire logic [15:0]          i_ink,
    input  wire logic [15:0]          i_paper,
    output logic                      o_ram_we,
    output logic [gpg_pkg::ADDR_W-1:0] o_ram_waddr,
    output logic [7:0]                o_ram_wdata,
    output logic                      o_ram_re,
    output logic [gpg_pkg::ADDR_W-1:0] o_ram_raddr,
    output logic                      o_tick_valid,
    output gpg_pkg::t_pix             o_pix
);
    import gpg_pkg::*;

    logic              r_drawing, n_drawing;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [3:0]        r_cell_row, n_cell_row;
    logic [2:0]        r_cell_col, n_cell_col;
    logic [REP_W-1:0]  r_rep_row, n_rep_row;
    logic [REP_W-1:0]  r_rep_col, n_rep_col;
    logic [8:0]        r_org_x, n_org_x;
    logic [8:0]        r_org_y, n_org_y;
    logic [3:0]        r_scale, n_scale;
    logic [15:0]       r_ink, n_ink;
    logic [15:0]       r_paper, n_paper;

    logic [3:0]  w_width;
    logic [4:0]  w_height;
    logic [4:0]  w_stride;
    logic [7:0]  w_idx;
    logic [12:0] w_prod;
    logic [8:0]  w_col_off, w_row_off;
    logic        w_end_rc, w_end_cc, w_end_rr, w_end_cr;
    logic        w_is_write, w_is_start, w_is_tick;

    assign w_width  = f_width(i_cfg.glyph_width);
    assign w_height = f_height(i_cfg.glyph_height);

    // Decode the command word
    always_comb begin
        w_is_write = 1'b0;
        w_is_start = 1'b0;
        w_is_tick  = 1'b0;
        unique case (i_command)
            CMD_WRITE: w_is_write = i_fire;
            CMD_START: w_is_start = i_fire;
            CMD_TICK:  w_is_tick  = i_fire & r_drawing;
            default:   ;
        endcase
    end

    // Glyph base from code and stride
    assign w_stride = i_cfg.column_order ? {1'b0, w_width} : w_height;
    assign w_idx    = ((i_char_code >= i_cfg.first_code) && (i_char_code <= i_cfg.last_code))
                      ? (i_char_code - i_cfg.first_code) : 8'd0;
    assign w_prod   = {5'd0, w_idx} * {8'd0, w_stride};

    // Counter wrap conditions
    assign w_end_rc = (5'(r_rep_col) + 5'd1) >= {1'b0, r_scale};
    assign w_end_cc = ({1'b0, r_cell_col} + 4'd1) >= w_width;
    assign w_end_rr = (5'(r_rep_row) + 5'd1) >= {1'b0, r_scale};
    assign w_end_cr = ({1'b0, r_cell_row} + 5'd1) >= w_height;

    // Screen offsets of the current pixel
    assign w_col_off = ({6'd0, r_cell_col} * {5'd0, r_scale}) + 9'(r_rep_col);
    assign w_row_off = ({5'd0, r_cell_row} * {5'd0, r_scale}) + 9'(r_rep_row);

    // Store accesses: font writes and pixel reads
    assign o_ram_we    = w_is_write;
    assign o_ram_waddr = ADDR_W'(i_font_address);
    assign o_ram_wdata = i_font_byte;
    assign o_ram_re    = w_is_tick;
    assign o_ram_raddr = r_base + (i_cfg.column_order ? ADDR_W'(r_cell_col)
                                                      : ADDR_W'(r_cell_row));

    // Pixel context for the shading stage
    assign o_tick_valid   = w_is_tick;
    assign o_pix.px       = r_org_x + w_col_off;
    assign o_pix.py       = r_org_y + w_row_off;
    assign o_pix.fore     = i_cfg.swap_ink_paper ? r_paper : r_ink;
    assign o_pix.back     = i_cfg.swap_ink_paper ? r_ink : r_paper;
    assign o_pix.bit_sel  = i_cfg.column_order ? r_cell_row[2:0] : r_cell_col;
    assign o_pix.row_tall = i_cfg.column_order & r_cell_row[3];
    assign o_pix.last     = w_end_rc & w_end_cc & w_end_rr & w_end_cr;

    // Latch on start, advance on tick
    always_comb begin
        n_drawing  = r_drawing;
        n_base     = r_base;
        n_cell_row = r_cell_row;
        n_cell_col = r_cell_col;
        n_rep_row  = r_rep_row;
        n_rep_col  = r_rep_col;
        n_org_x    = r_org_x;
        n_org_y    = r_org_y;
        n_scale    = r_scale;
        n_ink      = r_ink;
        n_paper    = r_paper;
        if (w_is_start) begin
            n_drawing  = 1'b1;
            n_base     = ADDR_W'(w_prod);
            n_cell_row = '0;
            n_cell_col = '0;
            n_rep_row  = '0;
            n_rep_col  = '0;
            n_org_x    = i_origin_x;
            n_org_y    = i_origin_y;
            n_scale    = f_scale(i_scale);
            n_ink      = i_ink;
            n_paper    = i_paper;
        end else if (w_is_tick) begin
            n_rep_col = r_rep_col + REP_W'(1);
            if (w_end_rc) begin
                n_rep_col  = '0;
                n_cell_col = r_cell_col + 3'd1;
                if (w_end_cc) begin
                    n_cell_col = '0;
                    n_rep_row  = r_rep_row + REP_W'(1);
                    if (w_end_rr) begin
                        n_rep_row  = '0;
                        n_cell_row = r_cell_row + 4'd1;
                        if (w_end_cr) begin
                            n_cell_row = '0;
                            n_drawing  = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawing  <= 1'b0;
            r_cell_row <= '0;
            r_cell_col <= '0;
            r_rep_row  <= '0;
            r_rep_col  <= '0;
        end else begin
            r_drawing  <= n_drawing;
            r_cell_row <= n_cell_row;
            r_cell_col <= n_cell_col;
            r_rep_row  <= n_rep_row;
            r_rep_col  <= n_rep_col;
        end
    end

    // Held character context
    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_org_x <= n_org_x;
        r_org_y <= n_org_y;
        r_scale <= n_scale;
        r_ink   <= n_ink;
        r_paper <= n_paper;
    end

endmodule

`default_nettype wire

>>> rtl/gpg_shade.sv
// Shading stage: picks the glyph bit from read data and holds the output word
`default_nettype none

module gpg_shade (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gpg_pkg::t_cfg i_cfg,
    input  wire logic          i_tick_valid,
    input  wire gpg_pkg::t_pix i_pix,
    input  wire logic [7:0]    i_rdata,
    input  wire logic          i_out_ready,
    output logic               o_stage_free,
    output logic               o_out_valid,
    output logic [8:0]         o_pixel_x,
    output logic [8:0]         o_pixel_y,
    output logic [15:0]        o_colour,
    output logic               o_write_enable,
    output logic               o_last_pixel
);
    import gpg_pkg::*;

    logic  r_p1_valid;
    t_pix  r_p1;
    logic  w_p1_move;
    logic  w_fg;

    assign w_p1_move    = r_p1_valid & (!o_out_valid | i_out_ready);
    assign o_stage_free = !r_p1_valid | w_p1_move;

    // Glyph bit: column bytes LSB at top, row bytes MSB at left
    always_comb begin
        if (i_cfg.column_order) begin
            w_fg = !r_p1.row_tall & i_rdata[r_p1.bit_sel];
        end else begin
            w_fg = ((i_rdata & (ROW_LEFT_BIT >> r_p1.bit_sel)) != 8'd0) ^ i_cfg.glyph_invert;
        end
    end

    // Read-wait stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (o_stage_free) begin
            r_p1_valid <= i_tick_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick_valid) begin
            r_p1 <= i_pix;
        end
    end

    // Output word valid: load from stage, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_p1_move) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p1_move) begin
            o_pixel_x      <= r_p1.px;
            o_pixel_y      <= r_p1.py;
            o_colour       <= w_fg ? r_p1.fore : r_p1.back;
            o_write_enable <= !(i_cfg.transparent & !w_fg);
            o_last_pixel   <= r_p1.last;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gpg_checker.sv
// Port-level assertions for the glyph pixel generator, bound to the top level
`default_nettype none

module gpg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic [1:0]  i_in_command,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [8:0]  i_out_x,
    input wire logic [8:0]  i_out_y,
    input wire logic [15:0] i_out_colour
);
    import gpg_pkg::*;

    // Reset empties the output word
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid after reset");

    // No word is accepted while in reset
    a_no_accept_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |-> !(i_in_valid && i_in_ready))
        else $error("input word accepted during reset");

    // A fresh pixel word stems from an accepted tick, through the read-wait stage
    a_pixel_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |->
            $past(i_in_valid && i_in_ready && (i_in_command == CMD_TICK), 2))
        else $error("pixel word without a matching tick");

    // A stalled pixel word holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_colour))
        else $error("stalled pixel word changed");

endmodule

bind glyph_pixel_generator gpg_checker u_gpg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_in_command (i_cmd.command),
    .i_out_valid  (o_pix.valid),
    .i_out_ready  (o_pix.ready),
    .i_out_x      (o_pix.pixel_x),
    .i_out_y      (o_pix.pixel_y),
    .i_out_colour (o_pix.colour)
);

`default_nettype wire
